### src/wls_pkg.sv
// Shared widths, register indexes and types for the windowed latency statistics unit.
`timescale 1ns / 1ps
package wls_pkg;

  localparam int SCOPE_W    = 6;
  localparam int US_W       = 24;
  localparam int CNT_W      = 32;
  localparam int SHARE_W    = 16;
  localparam int SHARE_FRAC = 10;
  localparam int WLEN_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int PCT_DIV    = 100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 4'd0,
    REG_SLOW_THR   = 4'd1,
    REG_WINDOW_LEN = 4'd2,
    REG_BUDGET     = 4'd3
  } cfg_reg_t;

endpackage

### src/wls_if.sv
// Valid/ready channel interfaces for sample items and result items.
`timescale 1ns / 1ps
interface wls_in_if;
  logic                        valid;
  logic                        ready;
  logic [wls_pkg::SCOPE_W-1:0] scope_index;
  logic [wls_pkg::US_W-1:0]    elapsed_us;

  modport source (output valid, scope_index, elapsed_us, input ready);
  modport sink (input valid, scope_index, elapsed_us, output ready);
endinterface

interface wls_out_if;
  logic                        valid;
  logic                        ready;
  logic [wls_pkg::SCOPE_W-1:0] scope_id;
  logic [wls_pkg::US_W-1:0]    last_us;
  logic [wls_pkg::CNT_W-1:0]   sample_count;
  logic [wls_pkg::CNT_W-1:0]   slow_count;
  logic [wls_pkg::US_W-1:0]    avg_us;
  logic [wls_pkg::US_W-1:0]    max_us;
  logic [wls_pkg::US_W-1:0]    p99_us;
  logic [wls_pkg::SHARE_W-1:0] budget_ratio;

  modport source (output valid, scope_id, last_us, sample_count, slow_count, avg_us, max_us,
                  p99_us, budget_ratio, input ready);
  modport sink (input valid, scope_id, last_us, sample_count, slow_count, avg_us, max_us,
                p99_us, budget_ratio, output ready);
endinterface

### src/wls_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wls_divider #(
  parameter int DW = 34,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   shifted;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign rem_nxt = ge ? VW'(shifted - {1'b0, dvs_r}) : VW'(shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      cnt_r <= CW'(DW);
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### src/wls_topk.sv
// Descending list of the largest samples seen in a window walk.
`timescale 1ns / 1ps
module wls_topk #(
  parameter int K  = 2,
  parameter int KW = 1
) (
  input  logic                     clk,
  input  logic                     clr,
  input  logic                     ins_en,
  input  logic [wls_pkg::US_W-1:0] ins_val,
  input  logic [KW-1:0]            sel,
  output logic [wls_pkg::US_W-1:0] sel_val,
  output logic [wls_pkg::US_W-1:0] max_val
);

  logic [wls_pkg::US_W-1:0] list_r   [K];
  logic [wls_pkg::US_W-1:0] list_nxt [K];
  logic [K-1:0]             above;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      above[i] = ins_val > list_r[i];
    end
    for (int i = 0; i < K; i++) begin
      if (!above[i]) begin
        list_nxt[i] = list_r[i];
      end else if (i == 0) begin
        list_nxt[i] = ins_val;
      end else if (!above[i-1]) begin
        list_nxt[i] = ins_val;
      end else begin
        list_nxt[i] = list_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < K; i++) begin
      if (clr) begin
        list_r[i] <= '0;
      end else if (ins_en) begin
        list_r[i] <= list_nxt[i];
      end
    end
  end

  assign sel_val = list_r[sel];
  assign max_val = list_r[0];

endmodule

### src/windowed_latency_statistics_unit.sv
// Windowed latency statistics unit: per-scope counters and window statistics over a sample ring.
`timescale 1ns / 1ps
// Each accepted sample (while enabled, for a scope below NUM_SCOPES) yields one result item;
// other samples are taken and dropped. Items are handled one at a time: a read-modify-write of
// the scope record, a walk of n window entries through the sample memory (one per cycle) that
// gathers sum, maximum and the top ceil(WINDOW_MAX/100) samples, then a bit-serial divide
// for the mean and, with a nonzero budget, a second one for the share. After reset the unit
// clears the scope records, and a window length write trims every scope record; no sample
// is taken during either pass.
module windowed_latency_statistics_unit #(
  parameter int NUM_SCOPES = 64,
  parameter int WINDOW_MAX = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wls_in_if.sink                         in_ch,
  wls_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [wls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wls_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SA_W  = (NUM_SCOPES > 1) ? $clog2(NUM_SCOPES) : 1;
  localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW    = $clog2(WINDOW_MAX + 1);
  localparam int SW    = wls_pkg::US_W + FW;
  localparam int QW    = wls_pkg::US_W + wls_pkg::SHARE_FRAC;
  localparam int DW    = (SW > QW) ? SW : QW;
  localparam int K     = (WINDOW_MAX + wls_pkg::PCT_DIV - 1) / wls_pkg::PCT_DIV;
  localparam int KW    = (K > 1) ? $clog2(K) : 1;
  localparam int MW    = $clog2(K + 1);
  localparam int CW    = $clog2(wls_pkg::PCT_DIV);
  localparam int WDEP  = NUM_SCOPES * (1 << PW);
  localparam int WL_RST = (128 > WINDOW_MAX) ? WINDOW_MAX : 128;

  typedef struct packed {
    logic [FW-1:0]               fill;
    logic [PW-1:0]               wp;
    logic [wls_pkg::CNT_W-1:0]   total;
    logic [wls_pkg::CNT_W-1:0]   slow;
  } meta_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_UPD   = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_AVG   = 6'b001000,
    ST_SHARE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r;

  // configuration
  logic                            enable_r;
  logic [wls_pkg::US_W-1:0]        thr_r;
  logic [FW-1:0]                   wl_r;
  logic [wls_pkg::US_W-1:0]        budget_r;
  logic [wls_pkg::WLEN_W-1:0]      wl_raw;
  logic [FW-1:0]                   wl_clamp;

  // record sweep (clear after reset, trim after length write)
  logic                            sweep_r;
  logic                            sweep_clr_r;
  logic                            sweep_ph_r;
  logic [SA_W-1:0]                 sweep_idx_r;
  logic [FW-1:0]                   trim_r;

  // memories
  meta_t                           meta_mem [NUM_SCOPES];
  meta_t                           meta_q_r;
  logic                            meta_we;
  logic                            meta_re;
  logic [SA_W-1:0]                 meta_waddr;
  logic [SA_W-1:0]                 meta_raddr;
  meta_t                           meta_wdata;
  meta_t                           meta_upd;
  meta_t                           meta_trim;
  logic [wls_pkg::US_W-1:0]        win_mem [WDEP];
  logic [wls_pkg::US_W-1:0]        rd_q_r;
  logic                            rd_v_r;
  logic                            win_re;

  // item datapath
  logic                            in_acc;
  logic                            in_use;
  logic [wls_pkg::SCOPE_W-1:0]     scope_r;
  logic [SA_W-1:0]                 saddr;
  logic [wls_pkg::US_W-1:0]        e_r;
  logic [FW-1:0]                   n_r;
  logic [PW-1:0]                   pos_r;
  logic [FW-1:0]                   issue_r;
  logic [SW-1:0]                   sum_r;
  logic [MW-1:0]                   m_r;
  logic [CW-1:0]                   c100_r;
  logic [wls_pkg::CNT_W-1:0]       total_r;
  logic [wls_pkg::CNT_W-1:0]       slow_r;
  logic [wls_pkg::US_W-1:0]        avg_r;
  logic [wls_pkg::SHARE_W-1:0]     share_r;
  logic                            walk_end;
  logic                            out_load;

  // divider
  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  logic [DW-1:0]                   div_q;
  logic [DW-1:0]                   div_dividend;
  logic [wls_pkg::US_W-1:0]        div_divisor;

  // top-k
  logic [KW-1:0]                   p99_sel;
  logic [wls_pkg::US_W-1:0]        p99_val;
  logic [wls_pkg::US_W-1:0]        max_val;

  // output register
  logic                            out_valid_r;
  logic [wls_pkg::SCOPE_W-1:0]     o_scope_r;
  logic [wls_pkg::US_W-1:0]        o_last_r;
  logic [wls_pkg::CNT_W-1:0]       o_total_r;
  logic [wls_pkg::CNT_W-1:0]       o_slow_r;
  logic [wls_pkg::US_W-1:0]        o_avg_r;
  logic [wls_pkg::US_W-1:0]        o_max_r;
  logic [wls_pkg::US_W-1:0]        o_p99_r;
  logic [wls_pkg::SHARE_W-1:0]     o_share_r;

  assign in_ch.ready = (state_r == ST_IDLE) && !sweep_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_use      = enable_r && (11'(in_ch.scope_index) < 11'(NUM_SCOPES));
  assign saddr       = SA_W'(scope_r);

  assign wl_raw   = cfg_wdata[wls_pkg::WLEN_W-1:0];
  assign wl_clamp = (wl_raw == '0) ? FW'(1) :
                    (11'(wl_raw) > 11'(WINDOW_MAX)) ? FW'(WINDOW_MAX) : FW'(wl_raw);

  // record update for the item
  always_comb begin
    meta_upd       = meta_q_r;
    meta_upd.total = (meta_q_r.total == '1) ? meta_q_r.total : meta_q_r.total + 1'b1;
    meta_upd.slow  = meta_q_r.slow;
    if (thr_r != '0 && e_r > thr_r && meta_q_r.slow != '1) begin
      meta_upd.slow = meta_q_r.slow + 1'b1;
    end
    meta_upd.wp   = (meta_q_r.wp == PW'(WINDOW_MAX - 1)) ? '0 : meta_q_r.wp + 1'b1;
    meta_upd.fill = (meta_q_r.fill < wl_r) ? meta_q_r.fill + 1'b1 : meta_q_r.fill;
  end

  always_comb begin
    meta_trim      = meta_q_r;
    meta_trim.fill = (meta_q_r.fill > trim_r) ? trim_r : meta_q_r.fill;
  end

  assign meta_we    = (state_r == ST_UPD) || (sweep_r && (sweep_clr_r || sweep_ph_r));
  assign meta_waddr = (state_r == ST_UPD) ? saddr : sweep_idx_r;
  assign meta_wdata = (state_r == ST_UPD) ? meta_upd : (sweep_clr_r ? '0 : meta_trim);
  assign meta_re    = (in_acc && in_use) || (sweep_r && !sweep_clr_r && !sweep_ph_r);
  assign meta_raddr = in_acc ? SA_W'(in_ch.scope_index) : sweep_idx_r;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_q_r <= meta_mem[meta_raddr];
    end
  end

  assign win_re = (state_r == ST_WALK) && (issue_r != n_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      win_mem[{saddr, meta_q_r.wp}] <= e_r;
    end
    if (win_re) begin
      rd_q_r <= win_mem[{saddr, pos_r}];
    end
  end

  assign walk_end     = (issue_r == n_r) && !rd_v_r;
  assign div_start    = ((state_r == ST_WALK) && walk_end) ||
                        ((state_r == ST_AVG) && div_done && budget_r != '0);
  assign div_dividend = (state_r == ST_WALK) ? DW'(sum_r) :
                        DW'({div_q[wls_pkg::US_W-1:0], {wls_pkg::SHARE_FRAC{1'b0}}});
  assign div_divisor  = (state_r == ST_WALK) ? wls_pkg::US_W'(n_r) : budget_r;
  assign out_load     = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign p99_sel      = KW'(m_r - 1'b1);

  wls_divider #(
    .DW(DW),
    .VW(wls_pkg::US_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  wls_topk #(
    .K (K),
    .KW(KW)
  ) u_topk (
    .clk     (clk),
    .clr     (state_r == ST_UPD),
    .ins_en  (rd_v_r),
    .ins_val (rd_q_r),
    .sel     (p99_sel),
    .sel_val (p99_val),
    .max_val (max_val)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b1;
      thr_r       <= '0;
      wl_r        <= FW'(WL_RST);
      budget_r    <= '0;
      sweep_r     <= 1'b1;
      sweep_clr_r <= 1'b1;
      sweep_ph_r  <= 1'b0;
      sweep_idx_r <= '0;
      trim_r      <= FW'(WL_RST);
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= win_re;

      if (cfg_wr_en) begin
        case (cfg_index)
          wls_pkg::REG_ENABLE:   enable_r <= cfg_wdata[0];
          wls_pkg::REG_SLOW_THR: thr_r    <= cfg_wdata[wls_pkg::US_W-1:0];
          wls_pkg::REG_BUDGET:   budget_r <= cfg_wdata[wls_pkg::US_W-1:0];
          wls_pkg::REG_WINDOW_LEN: begin
            wl_r <= wl_clamp;
          end
          default: ;
        endcase
      end

      if (cfg_wr_en && cfg_index == wls_pkg::REG_WINDOW_LEN && !(sweep_r && sweep_clr_r)) begin
        sweep_r     <= 1'b1;
        sweep_clr_r <= 1'b0;
        sweep_ph_r  <= 1'b0;
        sweep_idx_r <= '0;
        trim_r      <= (sweep_r && wl_clamp > trim_r) ? trim_r : wl_clamp;
      end else if (sweep_r) begin
        if (sweep_clr_r || sweep_ph_r) begin
          if (sweep_idx_r == SA_W'(NUM_SCOPES - 1)) begin
            sweep_r <= 1'b0;
          end else begin
            sweep_idx_r <= sweep_idx_r + 1'b1;
          end
        end
        if (!sweep_clr_r) begin
          sweep_ph_r <= !sweep_ph_r;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_use) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD:  state_r <= ST_WALK;
        ST_WALK: begin
          if (walk_end) begin
            state_r <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_done) begin
            state_r <= (budget_r == '0) ? ST_OUT : ST_SHARE;
          end
        end
        ST_SHARE: begin
          if (div_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      scope_r <= in_ch.scope_index;
      e_r     <= in_ch.elapsed_us;
    end
    if (state_r == ST_UPD) begin
      total_r <= meta_upd.total;
      slow_r  <= meta_upd.slow;
      n_r     <= meta_upd.fill;
      pos_r   <= meta_q_r.wp;
      issue_r <= '0;
      sum_r   <= '0;
      m_r     <= '0;
      c100_r  <= '0;
    end else begin
      if (win_re) begin
        pos_r   <= (pos_r == '0) ? PW'(WINDOW_MAX - 1) : pos_r - 1'b1;
        issue_r <= issue_r + 1'b1;
      end
      if (rd_v_r) begin
        sum_r <= sum_r + SW'(rd_q_r);
        if (c100_r == '0) begin
          m_r <= m_r + 1'b1;
        end
        c100_r <= (c100_r == CW'(wls_pkg::PCT_DIV - 1)) ? '0 : c100_r + 1'b1;
      end
    end
    if (state_r == ST_AVG && div_done) begin
      avg_r   <= div_q[wls_pkg::US_W-1:0];
      share_r <= '0;
    end
    if (state_r == ST_SHARE && div_done) begin
      share_r <= (|div_q[DW-1:wls_pkg::SHARE_W]) ? '1 : div_q[wls_pkg::SHARE_W-1:0];
    end
    if (out_load) begin
      o_scope_r <= scope_r;
      o_last_r  <= e_r;
      o_total_r <= total_r;
      o_slow_r  <= slow_r;
      o_avg_r   <= avg_r;
      o_max_r   <= max_val;
      o_p99_r   <= p99_val;
      o_share_r <= share_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scope_id     = o_scope_r;
  assign out_ch.last_us      = o_last_r;
  assign out_ch.sample_count = o_total_r;
  assign out_ch.slow_count   = o_slow_r;
  assign out_ch.avg_us       = o_avg_r;
  assign out_ch.max_us       = o_max_r;
  assign out_ch.p99_us       = o_p99_r;
  assign out_ch.budget_ratio = o_share_r;

`ifndef ASSERT_OFF
  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_use) |=> (state_r == ST_UPD))
    else $error("accepted item did not start its record update");

  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (n_r != '0 && issue_r <= n_r && n_r <= wl_r))
    else $error("window walk out of bounds");

  a_stats_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (p99_val <= max_val && avg_r <= max_val))
    else $error("window statistics inconsistent");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the windowed latency statistics unit.
`timescale 1ns / 1ps
module testbench;

  localparam int SCOPES = 64;
  localparam int WMAX = 128;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [wls_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef struct packed {
    logic [wls_pkg::SCOPE_W-1:0] scope_id;
    logic [wls_pkg::US_W-1:0]    last_us;
    logic [wls_pkg::CNT_W-1:0]   sample_count;
    logic [wls_pkg::CNT_W-1:0]   slow_count;
    logic [wls_pkg::US_W-1:0]    avg_us;
    logic [wls_pkg::US_W-1:0]    max_us;
    logic [wls_pkg::US_W-1:0]    p99_us;
    logic [wls_pkg::SHARE_W-1:0] budget_ratio;
  } stats_t;

  class latency_board;
    bit                        en;
    bit [wls_pkg::US_W-1:0]    slow_thr;
    int unsigned               win_len;
    bit [wls_pkg::US_W-1:0]    budget;
    bit [wls_pkg::US_W-1:0]    ring[SCOPES][WMAX];
    int unsigned               fill[SCOPES];
    int unsigned               wptr[SCOPES];
    bit [wls_pkg::CNT_W-1:0]   total[SCOPES];
    bit [wls_pkg::CNT_W-1:0]   slow[SCOPES];
    stats_t                    stats_q[$];
    int                        errors;

    function new();
      en = 1;
      slow_thr = 0;
      win_len = WMAX;
      budget = 0;
      errors = 0;
      foreach (fill[i]) begin
        fill[i] = 0;
        wptr[i] = 0;
        total[i] = 0;
        slow[i] = 0;
      end
    endfunction

    function void set_reg(logic [wls_pkg::CFG_IDX_W-1:0] idx,
                          logic [wls_pkg::CFG_DATA_W-1:0] val);
      int unsigned len;
      case (idx)
        wls_pkg::REG_ENABLE: en = val[0];
        wls_pkg::REG_SLOW_THR: slow_thr = val;
        wls_pkg::REG_WINDOW_LEN: begin
          len = val[wls_pkg::WLEN_W-1:0];
          if (len == 0) len = 1;
          if (len > WMAX) len = WMAX;
          win_len = len;
          foreach (fill[i]) if (fill[i] > len) fill[i] = len;
        end
        wls_pkg::REG_BUDGET: budget = val;
        default: ;
      endcase
    endfunction

    function void note_sample(bit [wls_pkg::SCOPE_W-1:0] s, bit [wls_pkg::US_W-1:0] e);
      stats_t r;
      int unsigned n;
      longint unsigned sum, avg, share;
      bit [wls_pkg::US_W-1:0] mx;
      bit [wls_pkg::US_W-1:0] w[];
      if (!en) return;
      if (total[s] != '1) total[s]++;
      if (slow_thr != 0 && e > slow_thr && slow[s] != '1) slow[s]++;
      ring[s][wptr[s]] = e;
      wptr[s] = (wptr[s] + 1) % WMAX;
      if (fill[s] < win_len) fill[s]++;
      n = fill[s];
      w = new[n];
      sum = 0;
      mx = 0;
      for (int k = 0; k < n; k++) begin
        w[k] = ring[s][(wptr[s] + 2 * WMAX - 1 - k) % WMAX];
        sum += w[k];
        if (w[k] > mx) mx = w[k];
      end
      w.sort();
      avg = sum / n;
      if (budget == 0) share = 0;
      else begin
        share = (avg << wls_pkg::SHARE_FRAC) / budget;
        if (share > 16'hFFFF) share = 16'hFFFF;
      end
      r.scope_id = s;
      r.last_us = e;
      r.sample_count = total[s];
      r.slow_count = slow[s];
      r.avg_us = avg[wls_pkg::US_W-1:0];
      r.max_us = mx;
      r.p99_us = w[(n * 99) / wls_pkg::PCT_DIV];
      r.budget_ratio = share[wls_pkg::SHARE_W-1:0];
      stats_q = {stats_q, r};
    endfunction

    function void check_result(stats_t act);
      stats_t exp_r;
      if (stats_q.size() == 0) begin
        $display("%0t: expected no result item, actual %p", $time, act);
        errors++;
        return;
      end
      exp_r = stats_q[0];
      stats_q.delete(0);
      if (act.scope_id !== exp_r.scope_id)
        report("scope_id", wls_pkg::CNT_W'(exp_r.scope_id), wls_pkg::CNT_W'(act.scope_id));
      if (act.last_us !== exp_r.last_us)
        report("last_us", wls_pkg::CNT_W'(exp_r.last_us), wls_pkg::CNT_W'(act.last_us));
      if (act.sample_count !== exp_r.sample_count)
        report("sample_count", exp_r.sample_count, act.sample_count);
      if (act.slow_count !== exp_r.slow_count)
        report("slow_count", exp_r.slow_count, act.slow_count);
      if (act.avg_us !== exp_r.avg_us)
        report("avg_us", wls_pkg::CNT_W'(exp_r.avg_us), wls_pkg::CNT_W'(act.avg_us));
      if (act.max_us !== exp_r.max_us)
        report("max_us", wls_pkg::CNT_W'(exp_r.max_us), wls_pkg::CNT_W'(act.max_us));
      if (act.p99_us !== exp_r.p99_us)
        report("p99_us", wls_pkg::CNT_W'(exp_r.p99_us), wls_pkg::CNT_W'(act.p99_us));
      if (act.budget_ratio !== exp_r.budget_ratio)
        report("budget_ratio", wls_pkg::CNT_W'(exp_r.budget_ratio),
               wls_pkg::CNT_W'(act.budget_ratio));
    endfunction

    function void report(string field, logic [wls_pkg::CNT_W-1:0] exp_v,
                         logic [wls_pkg::CNT_W-1:0] act_v);
      $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
      errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [wls_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wls_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit calm;
  longint cycles;
  latency_board board;

  wls_in_if in_ch();
  wls_out_if out_ch();

  windowed_latency_statistics_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.scope_id, out_ch.last_us, out_ch.sample_count,
                          out_ch.slow_count, out_ch.avg_us, out_ch.max_us, out_ch.p99_us,
                          out_ch.budget_ratio});
  end

  task automatic send_sample(bit [wls_pkg::SCOPE_W-1:0] s, bit [wls_pkg::US_W-1:0] e);
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.scope_index = s;
    in_ch.elapsed_us = e;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(s, e);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (board.stats_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [wls_pkg::CFG_IDX_W-1:0] idx,
                           logic [wls_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 0;
    board.set_reg(idx, val);
  endtask

  function automatic bit [wls_pkg::US_W-1:0] pick_elapsed();
    case ($urandom_range(9))
      0: return '1;
      1: return 0;
      2, 3, 4: return wls_pkg::US_W'($urandom_range(15));
      5, 6: return wls_pkg::US_W'($urandom_range(2000));
      default: return wls_pkg::US_W'($urandom);
    endcase
  endfunction

  function automatic logic [wls_pkg::CFG_DATA_W-1:0] pick_length();
    case ($urandom_range(7))
      0: return 0;
      1: return 1;
      2: return wls_pkg::CFG_DATA_W'($urandom_range(5));
      3: return wls_pkg::CFG_DATA_W'(WMAX);
      4: return wls_pkg::CFG_DATA_W'($urandom_range(255, WMAX + 1));
      default: return wls_pkg::CFG_DATA_W'($urandom_range(WMAX, 1));
    endcase
  endfunction

  function automatic logic [wls_pkg::CFG_DATA_W-1:0] pick_us();
    case ($urandom_range(5))
      0: return 0;
      1: return '1;
      2: return 1;
      3: return wls_pkg::CFG_DATA_W'($urandom_range(3000));
      default: return wls_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    board = new();
    clk = 0;
    rst_n = 0;
    calm = 0;
    cycles = 0;
    cfg_wr_en = 0;
    cfg_index = wls_pkg::REG_ENABLE;
    cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.scope_index = 0;
    in_ch.elapsed_us = 0;
    out_ch.ready = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;

    // reset defaults: no slow counting, full window, zero share
    send_sample(0, 0);
    send_sample(63, '1);
    send_sample(63, '1);
    send_sample(0, 7);
    send_sample(0, 7);
    send_sample(0, 3);
    write_reg(wls_pkg::REG_SLOW_THR, 1000);
    write_reg(wls_pkg::REG_BUDGET, 1);
    send_sample(1, 1000);
    send_sample(1, 1001);
    send_sample(1, '1);
    write_reg(wls_pkg::REG_WINDOW_LEN, 0);
    send_sample(0, 5);
    send_sample(63, 2);
    write_reg(wls_pkg::REG_WINDOW_LEN, 255);
    write_reg(wls_pkg::REG_BUDGET, '1);
    write_reg(wls_pkg::REG_SLOW_THR, '1);
    send_sample(0, '1);
    send_sample(63, 9);
    write_reg(wls_pkg::REG_ENABLE, 0);
    send_sample(2, 44);
    send_sample(63, 1);
    write_reg(REG_UNUSED, 0);
    write_reg(wls_pkg::REG_ENABLE, 1);
    send_sample(2, 45);
    write_reg(wls_pkg::REG_WINDOW_LEN, 3);
    send_sample(0, 6);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(wls_pkg::REG_WINDOW_LEN,
                ph == 7 ? wls_pkg::CFG_DATA_W'(WMAX) : pick_length());
      write_reg(wls_pkg::REG_SLOW_THR, pick_us());
      write_reg(wls_pkg::REG_BUDGET, pick_us());
      if (ph == 5) begin
        write_reg(wls_pkg::REG_ENABLE, 0);
        repeat (10) send_sample(wls_pkg::SCOPE_W'($urandom), wls_pkg::US_W'($urandom));
        write_reg(wls_pkg::REG_ENABLE, 1);
      end
      calm = (ph == 3);
      for (int i = 0; i < 200; i++) begin
        if (i == 100) drain();
        if ($urandom_range(9) < 6)
          send_sample(wls_pkg::SCOPE_W'($urandom_range(1)), pick_elapsed());
        else send_sample(wls_pkg::SCOPE_W'($urandom), pick_elapsed());
      end
      calm = 0;
    end

    drain();
    if (board.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
